/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL of the clause cost evaluator; used by the core.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, also checked while reset is high.
`define ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/wcce_pkg.sv */
// Package for the weighted clause cost evaluator: widths, codes, beat structs.
// No dependencies; imported by every module of the block except the queue.
`timescale 1ns / 1ps

package wcce_pkg;

   localparam int OP_W     = 2;
   localparam int WEIGHT_W = 48;
   localparam int LIT_W    = 18;
   localparam int MAG_W    = 18;
   localparam int NV_W     = 17;
   localparam int COST_W   = 63;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 1;

   localparam int DEFAULT_MAX_VARS   = 65536;
   localparam int DEFAULT_ITEM_DEPTH = 4;
   localparam int DEFAULT_RSP_DEPTH  = 4;

   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_VARIABLES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HARD_WEIGHT   = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD = 2'd0,
      OP_OPEN = 2'd1,
      OP_LIT  = 2'd2,
      OP_END  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_CLAUSE_DONE   = 3'd0,
      ST_FINAL_OK      = 3'd1,
      ST_HARD_VIOLATED = 3'd2,
      ST_LIT_RANGE     = 3'd3,
      ST_UNTERMINATED  = 3'd4,
      ST_FINAL_ERROR   = 3'd5
   } status_type;

   typedef struct packed {
      logic [NV_W-1:0]     num_variables;
      logic [WEIGHT_W-1:0] hard_weight;
   } cfg_type;

   typedef struct packed {
      op_type              op;
      logic [WEIGHT_W-1:0] weight;
      logic [MAG_W-1:0]    mag;
      logic [MAG_W-1:0]    quot;
      logic                negative;
      logic                lit_bad;
      logic                mag_zero;
      logic                bit_value;
   } item_type;

   typedef struct packed {
      status_type        status;
      logic              clause_satisfied;
      logic [COST_W-1:0] total_cost;
   } rsp_type;

endpackage

/* hw/rtl/wcce_fifo.sv */
// Small synchronous queue with a parameterized entry type.
// Depends on nothing; used for the item queue and the result queue.
`timescale 1ns / 1ps

module wcce_fifo #(
   parameter int  DEPTH      = 4,
   parameter type entry_type = logic
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  entry_type                    push_data,
   output logic                         full,
   input  logic                         pop,
   output entry_type                    pop_data,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type         store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign count = count_ff;

   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   assign wr_ptr_in = !do_push ? wr_ptr_ff :
                      (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !do_pop ? rd_ptr_ff :
                      (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);

   assign pop_data = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/wcce_front.sv */
// Front end: accepts request beats, takes literal magnitude, range flag and
// store quotient, and queues classified items. Depends on wcce_pkg, wcce_fifo.
`timescale 1ns / 1ps

module wcce_front #(
   parameter int MAX_VARS   = wcce_pkg::DEFAULT_MAX_VARS,
   parameter int ITEM_DEPTH = wcce_pkg::DEFAULT_ITEM_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wcce_pkg::cfg_type                   cfg,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [wcce_pkg::OP_W-1:0]           req_op,
   input  logic [wcce_pkg::WEIGHT_W-1:0]       req_weight,
   input  logic signed [wcce_pkg::LIT_W-1:0]   req_literal,
   input  logic                                req_bit_value,
   input  logic                                item_pop,
   output wcce_pkg::item_type                  item_head,
   output logic                                item_empty
);

   import wcce_pkg::*;

   localparam int AW      = $clog2(MAX_VARS);
   localparam int SHIFT   = MAG_W + AW;
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(MAX_VARS) - 64'd1) / 64'(MAX_VARS);
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W  = MAG_W + RECIP_W;

   logic [MAG_W-1:0]  raw;
   logic [MAG_W-1:0]  mag;
   logic              negative;
   logic [PROD_W-1:0] prod;
   item_type          item;

   assign raw      = $unsigned(req_literal);
   assign negative = req_literal[LIT_W-1];
   assign mag      = negative ? (~raw + 1'b1) : raw;

   // exact floor(mag / MAX_VARS) by reciprocal
   assign prod = PROD_W'(mag) * PROD_W'(RECIP);

   assign item.op        = op_type'(req_op);
   assign item.weight    = req_weight;
   assign item.mag       = mag;
   assign item.quot      = MAG_W'(prod >> SHIFT);
   assign item.negative  = negative;
   assign item.lit_bad   = (mag > {1'b0, cfg.num_variables}) ||
                           (32'(mag) > 32'(MAX_VARS));
   assign item.mag_zero  = (mag == '0);
   assign item.bit_value = req_bit_value;

   wcce_fifo #(
      .DEPTH      (ITEM_DEPTH),
      .entry_type (item_type)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (item),
      .full      (req_full),
      .pop       (item_pop),
      .pop_data  (item_head),
      .empty     (item_empty),
      .count     ()
   );

endmodule

/* hw/rtl/wcce_back.sv */
// Back end: assignment store access stage and clause state stage; issues
// items only with room in the result queue. Depends on wcce_pkg.
`timescale 1ns / 1ps

module wcce_back #(
   parameter int MAX_VARS  = wcce_pkg::DEFAULT_MAX_VARS,
   parameter int RSP_DEPTH = wcce_pkg::DEFAULT_RSP_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wcce_pkg::cfg_type                   cfg,
   input  logic                                item_empty,
   input  wcce_pkg::item_type                  item_head,
   output logic                                item_pop,
   input  logic [$clog2(RSP_DEPTH+1)-1:0]      rsp_count,
   output logic                                rsp_push,
   output wcce_pkg::rsp_type                   rsp_data
);

   import wcce_pkg::*;

   localparam int AW        = $clog2(MAX_VARS);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   logic                 s1_valid_ff, s2_valid_ff;
   item_type             s1_item_ff, s2_item_ff;
   logic                 s2_bit_ff;
   logic                 assign_mem [MAX_VARS];

   logic                 open_ff, open_in;
   logic                 true_ff, true_in;
   logic [WEIGHT_W-1:0]  weight_ff, weight_in;
   logic                 error_ff, error_in;
   logic [COST_W-1:0]    cost_ff, cost_in;

   logic [RSP_CNT_W:0]   inflight;
   logic [MAG_W-1:0]     quot_mul;
   logic [MAG_W-1:0]     rem;
   logic [AW-1:0]        addr;
   logic                 mem_we;
   logic                 lit_hit;
   logic [COST_W:0]      cost_sum;

   // issue only while every item in flight has a free result slot
   assign inflight = (RSP_CNT_W+1)'(rsp_count) + (RSP_CNT_W+1)'(s1_valid_ff)
                   + (RSP_CNT_W+1)'(s2_valid_ff);
   assign item_pop = !item_empty && (inflight < (RSP_CNT_W+1)'(RSP_DEPTH));

   // address is mag mod MAX_VARS
   assign quot_mul = s1_item_ff.quot * MAG_W'(MAX_VARS);
   assign rem      = s1_item_ff.mag - quot_mul;
   assign addr     = AW'(rem);
   assign mem_we   = s1_valid_ff && (s1_item_ff.op == OP_LOAD) && !error_in;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         assign_mem[addr] <= s1_item_ff.bit_value;
      end
      s2_bit_ff <= assign_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         open_ff     <= 1'b0;
         true_ff     <= 1'b0;
         weight_ff   <= '0;
         error_ff    <= 1'b0;
         cost_ff     <= '0;
      end else begin
         s1_valid_ff <= item_pop;
         s2_valid_ff <= s1_valid_ff;
         open_ff     <= open_in;
         true_ff     <= true_in;
         weight_ff   <= weight_in;
         error_ff    <= error_in;
         cost_ff     <= cost_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= item_head;
      s2_item_ff <= s1_item_ff;
   end

   assign lit_hit  = (s2_bit_ff == !s2_item_ff.negative);
   assign cost_sum = {1'b0, cost_ff} + (COST_W+1)'(weight_ff);

   always_comb begin
      open_in   = open_ff;
      true_in   = true_ff;
      weight_in = weight_ff;
      error_in  = error_ff;
      cost_in   = cost_ff;
      rsp_push  = 1'b0;
      rsp_data.status           = ST_CLAUSE_DONE;
      rsp_data.clause_satisfied = 1'b0;
      if (s2_valid_ff) begin
         unique case (s2_item_ff.op)
            OP_END: begin
               rsp_push = 1'b1;
               if (error_ff) begin
                  rsp_data.status = ST_FINAL_ERROR;
               end else if (open_ff) begin
                  rsp_data.status = ST_UNTERMINATED;
               end else begin
                  rsp_data.status = ST_FINAL_OK;
               end
               open_in   = 1'b0;
               true_in   = 1'b0;
               weight_in = '0;
               error_in  = 1'b0;
               cost_in   = '0;
            end
            OP_LOAD: begin
            end
            OP_OPEN: begin
               if (!error_ff) begin
                  if (open_ff) begin
                     error_in        = 1'b1;
                     open_in         = 1'b0;
                     rsp_push        = 1'b1;
                     rsp_data.status = ST_UNTERMINATED;
                  end else begin
                     open_in   = 1'b1;
                     true_in   = 1'b0;
                     weight_in = s2_item_ff.weight;
                  end
               end
            end
            OP_LIT: begin
               if (!error_ff && open_ff) begin
                  if (s2_item_ff.lit_bad) begin
                     error_in        = 1'b1;
                     open_in         = 1'b0;
                     rsp_push        = 1'b1;
                     rsp_data.status = ST_LIT_RANGE;
                  end else if (!s2_item_ff.mag_zero) begin
                     if (lit_hit) begin
                        true_in = 1'b1;
                     end
                  end else begin
                     open_in  = 1'b0;
                     rsp_push = 1'b1;
                     if (true_ff) begin
                        rsp_data.clause_satisfied = 1'b1;
                     end else if (weight_ff == cfg.hard_weight) begin
                        error_in        = 1'b1;
                        rsp_data.status = ST_HARD_VIOLATED;
                     end else begin
                        cost_in = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
                     end
                  end
               end
            end
         endcase
      end
      rsp_data.total_cost = (s2_item_ff.op == OP_END) ? cost_ff : cost_in;
   end

endmodule

/* hw/rtl/weighted_clause_cost_evaluator_core.sv */
// Path: an item waits in the item queue, passes the store access and clause state
// stages, and its result enters the result queue. Throughput: one item per cycle
// while the result queue has room for all items in flight, set by the single assignment store access per item.
// Reset (synchronous): empties both queues and the pipeline, clears cost and
// clause state, num_variables to 0, hard_weight to 1; the store is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module weighted_clause_cost_evaluator_core #(
   parameter int MAX_VARS   = wcce_pkg::DEFAULT_MAX_VARS,
   parameter int ITEM_DEPTH = wcce_pkg::DEFAULT_ITEM_DEPTH,
   parameter int RSP_DEPTH  = wcce_pkg::DEFAULT_RSP_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [wcce_pkg::OP_W-1:0]           req_op,
   input  logic [wcce_pkg::WEIGHT_W-1:0]       req_weight,
   input  logic signed [wcce_pkg::LIT_W-1:0]   req_literal,
   input  logic                                req_bit_value,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [wcce_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_clause_satisfied,
   output logic [wcce_pkg::COST_W-1:0]         rsp_total_cost,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wcce_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wcce_pkg::WEIGHT_W-1:0]       csr_wdata
);

   import wcce_pkg::*;

   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   logic [NV_W-1:0]     num_variables_ff;
   logic [WEIGHT_W-1:0] hard_weight_ff;
   cfg_type             cfg;

   logic                item_empty;
   logic                item_pop;
   item_type            item_head;

   logic                rsp_push;
   logic                rsp_full;
   rsp_type             rsp_in_data;
   rsp_type             rsp_out_data;
   logic [RSP_CNT_W-1:0] rsp_count;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_variables_ff <= '0;
         hard_weight_ff   <= WEIGHT_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NUM_VARIABLES: num_variables_ff <= csr_wdata[NV_W-1:0];
            CSR_HARD_WEIGHT:   hard_weight_ff   <= csr_wdata;
         endcase
      end
   end

   assign cfg.num_variables = num_variables_ff;
   assign cfg.hard_weight   = hard_weight_ff;

   wcce_front #(
      .MAX_VARS   (MAX_VARS),
      .ITEM_DEPTH (ITEM_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_op        (req_op),
      .req_weight    (req_weight),
      .req_literal   (req_literal),
      .req_bit_value (req_bit_value),
      .item_pop      (item_pop),
      .item_head     (item_head),
      .item_empty    (item_empty)
   );

   wcce_back #(
      .MAX_VARS  (MAX_VARS),
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_empty (item_empty),
      .item_head  (item_head),
      .item_pop   (item_pop),
      .rsp_count  (rsp_count),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_in_data)
   );

   wcce_fifo #(
      .DEPTH      (RSP_DEPTH),
      .entry_type (rsp_type)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_out_data),
      .empty     (rsp_empty),
      .count     (rsp_count)
   );

   assign rsp_status           = rsp_out_data.status;
   assign rsp_clause_satisfied = rsp_out_data.clause_satisfied;
   assign rsp_total_cost       = rsp_out_data.total_cost;

   `ASSERT_IMPLIES(a_rsp_no_overflow, clock, reset, rsp_push, !rsp_full, "result beat dropped")
   `ASSERT_IMPLIES(a_issue_has_item, clock, reset, item_pop, !item_empty, "issue from empty queue")
   `ASSERT_NEXT(a_reset_empties, clock, reset, rsp_empty && !req_full, "queues not empty after reset")

endmodule

/* verif/tb_weighted_clause_cost_evaluator_core.sv */
// Self-checking bench for weighted_clause_cost_evaluator_core: directed and random
// CNF streams with a cost tracker that predicts every report. Needs wcce_pkg and the core.
`timescale 1ns / 1ps

module tb_weighted_clause_cost_evaluator_core;
   import wcce_pkg::*;

   localparam int STORE_DEPTH = DEFAULT_MAX_VARS;

   class cost_tracker;
      logic [NV_W-1:0]     num_vars = '0;
      logic [WEIGHT_W-1:0] hard_wt = 48'd1;
      bit                  var_value [STORE_DEPTH];
      bit                  var_loaded [STORE_DEPTH];
      logic [COST_W-1:0]   cost = '0;
      bit                  in_clause = 0;
      bit                  lit_true = 0;
      bit                  err = 0;
      logic [WEIGHT_W-1:0] open_wt = '0;
      rsp_type             due_reports[$];
      int                  fails = 0;

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] data);
         if (idx == CSR_NUM_VARIABLES) begin
            num_vars = data[NV_W-1:0];
         end else begin
            hard_wt = data;
         end
      endfunction

      function logic [MAG_W-1:0] magnitude(logic [LIT_W-1:0] lit);
         return lit[LIT_W-1] ? (~lit + 1'b1) : lit;
      endfunction

      function bit reads_unloaded(op_type op, logic [LIT_W-1:0] lit);
         logic [MAG_W-1:0] m;
         m = magnitude(lit);
         return op == OP_LIT && !err && in_clause && m != 0 && m <= num_vars
            && m <= STORE_DEPTH && !var_loaded[m % STORE_DEPTH];
      endfunction

      function int pending();
         return due_reports.size();
      endfunction

      // Returns 1 when the beat has any effect on the block.
      function bit accept_item(op_type op, logic [WEIGHT_W-1:0] weight,
                               logic [LIT_W-1:0] lit, logic bv);
         rsp_type          r;
         logic [MAG_W-1:0] m;
         logic [63:0]      sum;
         m = magnitude(lit);
         r.status = ST_CLAUSE_DONE;
         r.clause_satisfied = 1'b0;
         r.total_cost = cost;
         if (op == OP_END) begin
            r.status = err ? ST_FINAL_ERROR : (in_clause ? ST_UNTERMINATED : ST_FINAL_OK);
            due_reports.push_back(r);
            cost = '0;
            in_clause = 0;
            lit_true = 0;
            open_wt = '0;
            err = 0;
            return 1;
         end
         if (err) return 0;
         if (op == OP_LOAD) begin
            var_value[m % STORE_DEPTH] = bv;
            var_loaded[m % STORE_DEPTH] = 1;
            return 1;
         end
         if (op == OP_OPEN) begin
            if (in_clause) begin
               err = 1;
               in_clause = 0;
               r.status = ST_UNTERMINATED;
               due_reports.push_back(r);
            end else begin
               in_clause = 1;
               lit_true = 0;
               open_wt = weight;
            end
            return 1;
         end
         if (!in_clause) return 0;
         if (m > num_vars || m > STORE_DEPTH) begin
            err = 1;
            in_clause = 0;
            r.status = ST_LIT_RANGE;
            due_reports.push_back(r);
         end else if (m != 0) begin
            if (var_value[m % STORE_DEPTH] == !lit[LIT_W-1]) lit_true = 1;
         end else begin
            in_clause = 0;
            if (lit_true) begin
               r.clause_satisfied = 1'b1;
            end else if (open_wt == hard_wt) begin
               err = 1;
               r.status = ST_HARD_VIOLATED;
            end else begin
               sum = {1'b0, cost} + open_wt;
               cost = (sum > COST_MAX) ? COST_MAX : sum[COST_W-1:0];
               r.total_cost = cost;
            end
            due_reports.push_back(r);
         end
         return 1;
      endfunction

      function void flag(string field, logic [63:0] want, logic [63:0] got);
         fails++;
         // quiet after the first hundred
         if (fails <= 100) $error("%s: expected %0d, actual %0d", field, want, got);
      endfunction

      function void check_report(logic [STATUS_W-1:0] status, logic sat,
                                 logic [COST_W-1:0] total);
         rsp_type e;
         if (due_reports.size() == 0) begin
            fails++;
            if (fails <= 100) $error("unexpected result beat: status %0d", status);
            return;
         end
         e = due_reports.pop_front();
         if (status !== e.status) flag("status", 64'(e.status), 64'(status));
         if (sat !== e.clause_satisfied) flag("clause_satisfied", 64'(e.clause_satisfied),
                                              64'(sat));
         if (total !== e.total_cost) flag("total_cost", 64'(e.total_cost), 64'(total));
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic [OP_W-1:0]            req_op = OP_LOAD;
   logic [WEIGHT_W-1:0]        req_weight = '0;
   logic signed [LIT_W-1:0]    req_literal = '0;
   logic                       req_bit_value = 1'b0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic                       rsp_clause_satisfied;
   logic [COST_W-1:0]          rsp_total_cost;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [WEIGHT_W-1:0]        csr_wdata = '0;

   cost_tracker sb = new;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          counted = 0;

   weighted_clause_cost_evaluator_core dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_op(req_op),
      .req_weight(req_weight),
      .req_literal(req_literal),
      .req_bit_value(req_bit_value),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_status(rsp_status),
      .rsp_clause_satisfied(rsp_clause_satisfied),
      .rsp_total_cost(rsp_total_cost),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5ns clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         sb.check_report(rsp_status, rsp_clause_satisfied, rsp_total_cost);
      end
      rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [WEIGHT_W-1:0] rand_weight();
      return {16'($urandom()), $urandom()};
   endfunction

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(5))
         0: return sb.hard_wt;
         1: return '0;
         2: return '1;
         3: return 48'($urandom_range(1000));
         default: return rand_weight();
      endcase
   endfunction

   function automatic logic [LIT_W-1:0] pick_lit();
      int v, top;
      top = int'(sb.num_vars);
      if (top == 0) return '0;
      case ($urandom_range(9))
         0: v = top;
         1, 2: v = $urandom_range(top, 1);
         default: v = $urandom_range(top < 24 ? top : 24, 1);
      endcase
      return $urandom_range(1) ? 18'(-v) : 18'(v);
   endfunction

   task automatic push_raw(op_type op, logic [WEIGHT_W-1:0] w, logic [LIT_W-1:0] lit,
                           logic bv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_op <= op;
      req_weight <= w;
      req_literal <= lit;
      req_bit_value <= bv;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (sb.accept_item(op, w, lit, bv)) counted++;
   endtask

   // Load a variable before its first read.
   task automatic push_beat(op_type op, logic [WEIGHT_W-1:0] w, logic [LIT_W-1:0] lit,
                            logic bv);
      if (sb.reads_unloaded(op, lit)) push_raw(OP_LOAD, rand_weight(), lit, $urandom_range(1));
      push_raw(op, w, lit, bv);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(logic [NV_W-1:0] nv, logic [WEIGHT_W-1:0] hw);
      csr_valid <= 1'b1;
      csr_index <= CSR_NUM_VARIABLES;
      csr_wdata <= 48'(nv);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(CSR_NUM_VARIABLES, 48'(nv));
      csr_index <= CSR_HARD_WEIGHT;
      csr_wdata <= hw;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(CSR_HARD_WEIGHT, hw);
      csr_valid <= 1'b0;
   endtask

   task automatic random_stream(int quota);
      int stop_at, roll, n;
      stop_at = counted + quota;
      while (counted < stop_at) begin
         roll = $urandom_range(99);
         if ((sb.err && roll < 80) || roll < 8) begin
            push_beat(OP_END, rand_weight(), 18'($urandom()), $urandom_range(1));
         end else if (roll < 22) begin
            repeat ($urandom_range(3, 1)) begin
               push_beat(op_type'(2'($urandom_range(3))), rand_weight(), 18'($urandom()),
                         $urandom_range(1));
            end
         end else begin
            if ($urandom_range(3) == 0) begin
               push_beat(OP_LOAD, rand_weight(), pick_lit(), $urandom_range(1));
            end
            push_beat(OP_OPEN, pick_weight(), 18'($urandom()), $urandom_range(1));
            n = $urandom_range(4);
            repeat (n) begin
               if ($urandom_range(9) == 0) begin
                  push_beat(OP_LOAD, rand_weight(), pick_lit(), $urandom_range(1));
               end
               if (sb.num_vars != 0) begin
                  push_beat(OP_LIT, rand_weight(), pick_lit(), $urandom_range(1));
               end
            end
            push_beat(OP_LIT, rand_weight(), '0, $urandom_range(1));
         end
      end
   endtask

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: store addressing, every status, ignored beats
      configure(17'd65536, 48'd100);
      push_beat(OP_LOAD, '1, 18'h20000, 1'b0);
      push_beat(OP_LOAD, '0, 18'd65536, 1'b1);
      push_beat(OP_LOAD, '0, 18'd1, 1'b1);
      push_beat(OP_LOAD, '0, 18'(-2), 1'b0);
      push_beat(OP_LOAD, '0, 18'd131071, 1'b1);
      push_beat(OP_LIT, '0, 18'd3, 1'b1);
      push_beat(OP_OPEN, 48'd5, '0, 1'b0);
      push_beat(OP_LIT, '0, 18'd2, 1'b0);
      push_beat(OP_LIT, '0, 18'(-1), 1'b0);
      push_beat(OP_LIT, '0, '0, 1'b0);
      push_beat(OP_OPEN, '1, '1, 1'b1);
      push_beat(OP_LIT, '0, 18'd65535, 1'b0);
      push_beat(OP_LIT, '0, '0, 1'b0);
      push_beat(OP_OPEN, 48'd100, '0, 1'b0);
      push_beat(OP_LIT, '0, '0, 1'b0);
      push_beat(OP_OPEN, '0, '0, 1'b0);
      push_beat(OP_LOAD, '0, 18'd2, 1'b1);
      push_beat(OP_END, '0, '0, 1'b0);
      push_beat(OP_OPEN, '0, '0, 1'b0);
      push_beat(OP_LIT, '0, 18'h20000, 1'b0);
      push_beat(OP_END, '0, '0, 1'b0);
      push_beat(OP_OPEN, 48'd7, '0, 1'b0);
      push_beat(OP_OPEN, 48'd8, '0, 1'b0);
      push_beat(OP_END, '0, '0, 1'b0);
      push_beat(OP_OPEN, 48'd9, '0, 1'b0);
      push_beat(OP_END, '0, '0, 1'b0);
      push_beat(OP_END, '0, '0, 1'b0);
      drain();

      configure(17'd65536, 48'd0);
      random_stream(120);
      push_beat(OP_END, '0, '0, 1'b0);
      drain();

      send_idle_pct = 84;
      configure(17'd0, '1);
      random_stream(80);
      push_beat(OP_END, '0, '0, 1'b0);
      drain();

      send_idle_pct = 0;
      recv_stall_pct = 84;
      configure(17'($urandom_range(400, 1)), 48'($urandom_range(4, 1)));
      random_stream(150);
      push_beat(OP_END, '0, '0, 1'b0);
      drain();

      send_idle_pct = 22;
      recv_stall_pct = 22;
      configure(17'd65535, 48'd1);
      random_stream(75);
      drain();
      random_stream(75);
      push_beat(OP_END, '0, '0, 1'b0);
      drain();

      // back to back maximum soft weights
      send_idle_pct = 0;
      recv_stall_pct = 0;
      configure(17'd65536, 48'd1);
      repeat (8) begin
         push_beat(OP_OPEN, '1, '0, 1'b0);
         push_beat(OP_LIT, '0, '0, 1'b0);
      end
      push_beat(OP_END, '0, '0, 1'b0);
      push_beat(OP_END, '0, '0, 1'b0);

      req_push <= 1'b0;
      for (int c = 0; c < 50000 && sb.pending() != 0; c++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.fails++;
         $error("results missing: %0d", sb.pending());
      end
      if (sb.fails == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
